/* hdl/ctrs_pkg.sv */
`default_nettype none

package ctrs_pkg;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANK  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // two guard bits above a 32-bit count: sign and carry
  localparam int unsigned OPW = 34;

  typedef struct packed {
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    logic           sub;
  } alu_req_t;

  typedef struct packed {
    logic [OPW-1:0] sum;
    logic           neg;
    logic           zero;
    logic           wide;
  } alu_res_t;

endpackage

`default_nettype wire

/* hdl/ctrs_alu.sv */
`default_nettype none

module ctrs_alu (
  input  wire ctrs_pkg::alu_req_t req,
  output ctrs_pkg::alu_res_t      res
);

  logic [ctrs_pkg::OPW-1:0] bx;
  logic [ctrs_pkg::OPW-1:0] sum;

  always_comb begin
    bx  = req.sub ? ~req.b : req.b;
    sum = req.a + bx + {{(ctrs_pkg::OPW-1){1'b0}}, req.sub};
    res.sum  = sum;
    res.neg  = sum[ctrs_pkg::OPW-1];
    res.zero = (sum == '0);
    res.wide = (sum[ctrs_pkg::OPW-1:ctrs_pkg::OPW-2] == 2'b01);
  end

endmodule

`default_nettype wire

/* hdl/count_tree_rank_select_core.sv */
`default_nettype none

// Rank selection over per-class item counts, kept as a binary count tree.
// A request is taken when start is high and busy is low. func selects add
// (change the count of class_index by the signed amount) or take (find the
// class holding the rank-th item and remove one item from it).
// Each request gives exactly one result: done is high for one cycle with
// found_class and status valid. The receiver cannot stall; results are
// never held. The tree lives in one memory of 2*LEAVES words with one
// registered read and one write per cycle, worked by a single shared adder.
// Sequence of each request:
//   add rejected for class range: answered from idle, busy stays low
//   add: root read, leaf check, then the walk up level by level
//   take: root check, the walk down level by level, the leaf decrement,
//   then the walk up; a rank of zero or above the total answers at the
//   root check.
// Reset starts a clearing pass over all 2*LEAVES memory words; busy is
// high throughout and no request is taken until it ends.
module count_tree_rank_select_core #(
  parameter int LEAVES = 1024
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire               func,
  input  wire        [10:0] class_index,
  input  wire signed [31:0] amount,
  input  wire        [31:0] rank,
  output logic              done,
  output logic       [10:0] found_class,
  output logic       [1:0]  status
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int NW     = LEVELS + 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_TOTAL = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_RANK  = 8'b0001_0000,
    S_DESC  = 8'b0010_0000,
    S_DEC   = 8'b0100_0000,
    S_UP    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [NW-1:0] node, node_next;
  logic [31:0]   cur, cur_next;
  logic [31:0]   r, r_next;
  logic [31:0]   amt, amt_next;
  logic          too_big, too_big_next;
  logic [10:0]   taken, taken_next;
  logic          done_next;
  logic [10:0]   found_class_next;
  logic [1:0]    status_next;

  logic [31:0]   mem [2**NW];
  logic          we;
  logic [NW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  ctrs_pkg::alu_req_t req;
  ctrs_pkg::alu_res_t res;

  ctrs_alu u_alu (.req(req), .res(res));

  logic          cls_bad;
  logic [31:0]   cls_m1;
  logic [NW-1:0] leaf_addr;
  logic [31:0]   leaf_num;
  logic          le;
  logic [NW-1:0] nn;
  logic [NW-1:0] parent;

  assign busy = (state != S_IDLE);

  always_comb begin
    cls_bad   = (class_index == 11'd0) || (32'(class_index) > 32'(LEAVES));
    cls_m1    = 32'(class_index) - 32'd1;
    leaf_addr = {1'b1, cls_m1[LEVELS-1:0]};
    leaf_num  = 32'(node[LEVELS-1:0]) + 32'd1;
    le        = res.neg | res.zero;
    nn        = {node[NW-2:0], ~le};
    parent    = {1'b0, node[NW-1:1]};
  end

  // operand selection for the shared adder
  always_comb begin
    req.a   = '0;
    req.b   = '0;
    req.sub = 1'b0;
    unique case (state)
      S_TOTAL, S_CHECK: begin
        req.a = {2'b00, rdata};
        req.b = {{2{amt[31]}}, amt};
      end
      S_RANK, S_DESC: begin
        req.a   = {2'b00, r};
        req.b   = {2'b00, rdata};
        req.sub = 1'b1;
      end
      S_DEC: begin
        req.a   = {2'b00, rdata};
        req.b   = {33'd0, (rdata != 32'd0)};
        req.sub = 1'b1;
      end
      S_UP: begin
        req.a = {2'b00, cur};
        req.b = {2'b00, rdata};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next       = state;
    node_next        = node;
    cur_next         = cur;
    r_next           = r;
    amt_next         = amt;
    too_big_next     = too_big;
    taken_next       = taken;
    done_next        = 1'b0;
    found_class_next = found_class;
    status_next      = status;
    we               = 1'b0;
    waddr            = node;
    wdata            = res.sum[31:0];
    raddr            = NW'(1);
    unique case (state)
      S_CLEAR: begin
        we        = 1'b1;
        wdata     = 32'd0;
        node_next = node + NW'(1);
        if (node == {NW{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (func == ctrs_pkg::FUNC_TAKE) begin
            r_next     = rank;
            state_next = S_RANK;
          end else if (cls_bad) begin
            done_next        = 1'b1;
            found_class_next = 11'd0;
            status_next      = ctrs_pkg::STATUS_RANGE;
          end else begin
            node_next  = leaf_addr;
            amt_next   = amount;
            taken_next = 11'd0;
            state_next = S_TOTAL;
          end
        end
      end
      S_TOTAL: begin
        too_big_next = res.wide;
        raddr        = node;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (res.neg || too_big) begin
          done_next        = 1'b1;
          found_class_next = 11'd0;
          status_next      = ctrs_pkg::STATUS_RANGE;
          state_next       = S_IDLE;
        end else begin
          we         = 1'b1;
          cur_next   = res.sum[31:0];
          raddr      = node ^ NW'(1);
          state_next = S_UP;
        end
      end
      S_RANK: begin
        if ((r == 32'd0) || !le) begin
          done_next        = 1'b1;
          found_class_next = 11'd0;
          status_next      = ctrs_pkg::STATUS_RANK;
          state_next       = S_IDLE;
        end else begin
          node_next  = NW'(1);
          raddr      = NW'(2);
          state_next = S_DESC;
        end
      end
      S_DESC: begin
        node_next = nn;
        if (!le) begin
          r_next = res.sum[31:0];
        end
        if (nn[NW-1]) begin
          raddr      = nn;
          state_next = S_DEC;
        end else begin
          raddr = {nn[NW-2:0], 1'b0};
        end
      end
      S_DEC: begin
        we         = 1'b1;
        cur_next   = res.sum[31:0];
        taken_next = leaf_num[10:0];
        raddr      = node ^ NW'(1);
        state_next = S_UP;
      end
      S_UP: begin
        we    = 1'b1;
        waddr = parent;
        if (parent == NW'(1)) begin
          done_next        = 1'b1;
          found_class_next = taken;
          status_next      = ctrs_pkg::STATUS_OK;
          state_next       = S_IDLE;
        end else begin
          node_next = parent;
          cur_next  = res.sum[31:0];
          raddr     = parent ^ NW'(1);
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      node  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      node  <= node_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    r           <= r_next;
    amt         <= amt_next;
    too_big     <= too_big_next;
    taken       <= taken_next;
    found_class <= found_class_next;
    status      <= status_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result issued while request still in flight");

  a_err_no_class: assert property (@(posedge clk) disable iff (rst)
    (done && status != ctrs_pkg::STATUS_OK) |-> found_class == 11'd0)
    else $error("error result carries a class");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == ctrs_pkg::FUNC_TAKE) |=> state == S_RANK)
    else $error("take request not started");

  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    state == S_UP |-> node != NW'(1))
    else $error("ascent past the root");

  a_desc_inner: assert property (@(posedge clk) disable iff (rst)
    state == S_DESC |-> !node[NW-1])
    else $error("descent continued below a leaf");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int LEAVES = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_REQUESTS = 1200;

  typedef struct {
    logic               func;
    logic        [10:0] cls;
    logic signed [31:0] amt;
    logic        [31:0] rnk;
  } request_t;

  typedef struct {
    logic [10:0] found;
    logic [1:0]  status;
  } answer_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               func;
  logic        [10:0] class_index;
  logic signed [31:0] amount;
  logic        [31:0] rank;
  logic               done;
  logic        [10:0] found_class;
  logic        [1:0]  status;

  count_tree_rank_select_core #(
    .LEAVES(LEAVES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .class_index(class_index),
    .amount(amount),
    .rank(rank),
    .done(done),
    .found_class(found_class),
    .status(status)
  );

  logic [31:0] count_tree [1:2*LEAVES-1];
  request_t    pending_requests[$];
  answer_t     expected_answers[$];
  int          mismatches;
  logic        taken;
  int          burst_left;
  int          idle_left;
  logic        start_next;
  request_t    next_req;
  request_t    seen_req;
  answer_t     got;
  answer_t     want;
  int          est_total;

  always #5 clk = ~clk;

  function automatic void resum_ancestors(int unsigned node);
    while (node > 1) begin
      node = node >> 1;
      count_tree[node] = count_tree[2*node] + count_tree[2*node+1];
    end
  endfunction

  function automatic answer_t apply_to_tree(request_t r);
    answer_t     a;
    int unsigned leaf;
    int unsigned node;
    longint      old_leaf;
    longint      new_leaf;
    longint      new_total;
    longint      rest;
    longint      left_cnt;
    a.found = '0;
    a.status = ctrs_pkg::STATUS_OK;
    if (r.func == ctrs_pkg::FUNC_ADD) begin
      if (r.cls == 0 || r.cls > LEAVES) begin
        a.status = ctrs_pkg::STATUS_RANGE;
      end else begin
        leaf = LEAVES + r.cls - 1;
        old_leaf = longint'({32'd0, count_tree[leaf]});
        new_leaf = old_leaf + longint'(r.amt);
        new_total = longint'({32'd0, count_tree[1]}) - old_leaf + new_leaf;
        if (new_leaf < 0 || new_total > 64'sh0000_0000_FFFF_FFFF) begin
          a.status = ctrs_pkg::STATUS_RANGE;
        end else begin
          count_tree[leaf] = new_leaf[31:0];
          resum_ancestors(leaf);
        end
      end
    end else begin
      if (r.rnk == 0 || r.rnk > count_tree[1]) begin
        a.status = ctrs_pkg::STATUS_RANK;
      end else begin
        node = 1;
        rest = longint'({32'd0, r.rnk});
        while (node < LEAVES) begin
          left_cnt = longint'({32'd0, count_tree[2*node]});
          if (rest <= left_cnt) begin
            node = 2 * node;
          end else begin
            rest = rest - left_cnt;
            node = 2 * node + 1;
          end
        end
        if (count_tree[node] > 0) count_tree[node] = count_tree[node] - 1;
        resum_ancestors(node);
        a.found = 11'(node - LEAVES + 1);
      end
    end
    return a;
  endfunction

  function automatic void note_mismatch(string what, answer_t w, answer_t g);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected class %0d status %0d, got class %0d status %0d",
               what, w.found, w.status, g.found, g.status);
  endfunction

  task automatic push_add(logic [10:0] cls, logic signed [31:0] amt);
    request_t r;
    r.func = ctrs_pkg::FUNC_ADD;
    r.cls = cls;
    r.amt = amt;
    r.rnk = $urandom;
    pending_requests.push_back(r);
  endtask

  task automatic push_take(logic [31:0] rnk);
    request_t r;
    r.func = ctrs_pkg::FUNC_TAKE;
    r.cls = 11'($urandom_range(0, 2047));
    r.amt = $urandom;
    r.rnk = rnk;
    pending_requests.push_back(r);
  endtask

  function automatic logic [10:0] pick_class();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return 11'($urandom_range(1, 16));
    if (sel == 1) return 11'($urandom_range(LEAVES - 8, LEAVES));
    return 11'($urandom_range(1, LEAVES));
  endfunction

  // driver: requests presented on the falling edge, held until taken
  always @(negedge clk) begin
    start_next = start;
    if (rst) begin
      start_next = 1'b0;
    end else begin
      if (start && taken) start_next = 1'b0;
      if (!start_next) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          func <= next_req.func;
          class_index <= next_req.cls;
          amount <= next_req.amt;
          rank <= next_req.rnk;
          start_next = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            idle_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 6);
          end
        end
      end
    end
    start <= start_next;
  end

  // monitor: results checked before the request taken on the same edge is predicted
  always @(posedge clk) begin
    if (done === 1'b1) begin
      got.found = found_class;
      got.status = status;
      if (expected_answers.size() == 0) begin
        want.found = 'x;
        want.status = 'x;
        note_mismatch("no request outstanding", want, got);
      end else begin
        want = expected_answers.pop_front();
        if (got.found !== want.found) note_mismatch("found_class", want, got);
        if (got.status !== want.status) note_mismatch("status", want, got);
      end
    end
    taken = !rst && start && (busy === 1'b0);
    if (taken) begin
      seen_req.func = func;
      seen_req.cls = class_index;
      seen_req.amt = amount;
      seen_req.rnk = rank;
      expected_answers.push_back(apply_to_tree(seen_req));
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int sel;
    int amt_small;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    func = ctrs_pkg::FUNC_ADD;
    class_index = '0;
    amount = '0;
    rank = '0;
    taken = 1'b0;
    mismatches = 0;
    burst_left = 0;
    idle_left = 0;
    est_total = 0;
    foreach (count_tree[i]) count_tree[i] = '0;

    // empty tree, bad ranks and bad classes
    push_take(32'd1);
    push_take(32'd0);
    push_add(11'd0, 32'sd7);
    push_add(11'd1025, 32'sd7);
    push_add(11'd2047, -32'sd1);
    // fill the total to its ceiling, then overflow
    push_add(11'd1, 32'h7FFF_FFFF);
    push_add(11'(LEAVES), 32'h7FFF_FFFF);
    push_add(11'd512, 32'sd1);
    push_add(11'd2, 32'sd1);
    push_take(32'hFFFF_FFFF);
    push_take(32'h8000_0000);
    push_take(32'hFFFF_FFFF);
    // negative counts, then drain back to empty
    push_add(11'd1, 32'h8000_0000);
    push_add(11'd1, 32'h8000_0001);
    push_add(11'(LEAVES), 32'h8000_0002);
    push_add(11'd3, 32'sd0);
    push_add(11'd1, 32'sd5);
    push_add(11'(LEAVES), 32'sd3);
    push_take(32'd5);
    push_take(32'd5);
    push_take(32'd7);
    push_add(11'd1, -32'sd5);
    push_add(11'd1, -32'sd4);
    push_add(11'(LEAVES), -32'sd2);

    repeat (RANDOM_REQUESTS) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        amt_small = $urandom_range(1, 40);
        push_add(pick_class(), 32'(amt_small));
        est_total += amt_small;
      end else if (sel < 50) begin
        push_add(pick_class(), -32'($urandom_range(1, 20)));
      end else if (sel < 85) begin
        push_take(32'($urandom_range(1, est_total + 2)));
        if (est_total > 0) est_total--;
      end else if (sel < 90) begin
        push_add(($urandom_range(0, 4) == 0) ? 11'd0 : 11'($urandom_range(LEAVES + 1, 2047)),
                 $urandom);
      end else if (sel < 95) begin
        push_take($urandom);
      end else if (sel < 98) begin
        push_add(pick_class(), $urandom);
      end else if (sel == 98) begin
        push_add(pick_class(), 32'sd0);
      end else begin
        push_take(32'd0);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_answers.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
